/* hdl/rbr_pkg.sv */
// Package for the rational box resampler: sizes, register map, reset values,
// and the command/status structs shared by controller and datapath.
// No dependencies.
package rbr_pkg;

    // Default structural parameters
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_FACTOR = 16;

    // Fixed field widths
    localparam int CHAN_W       = 8;
    localparam int COL_OUT_W    = 12;
    localparam int CFG_FACTOR_W = 5;
    localparam int CFG_WIDTH_W  = 13;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    // Register map (word index = paddr[3:2])
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_UP_FACTOR   = 2'd0;
    localparam reg_idx_t REG_DOWN_FACTOR = 2'd1;
    localparam reg_idx_t REG_LINE_WIDTH  = 2'd2;

    // Register reset values
    localparam logic [CFG_FACTOR_W-1:0] UP_FACTOR_RST   = 5'd1;
    localparam logic [CFG_FACTOR_W-1:0] DOWN_FACTOR_RST = 5'd1;
    localparam logic [CFG_WIDTH_W-1:0]  LINE_WIDTH_RST  = 13'd4096;

    // Input opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_FACTOR_W-1:0] up_factor;
        logic [CFG_FACTOR_W-1:0] down_factor;
        logic [CFG_WIDTH_W-1:0]  line_width;
    } cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic start;     // latch pixel, load repeat count
        logic clear;     // zero sums, count and column
        logic step;      // one repeat: add pixel into sums
        logic div_run;   // one divider iteration
        logic out_load;  // move quotient into output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic emit;       // this step completes an output pixel
        logic keep;       // column still inside the kept width
        logic step_more;  // repeats remain after this step
        logic div_done;   // divider on its final iteration
        logic out_free;   // output register can take a result
        logic item_more;  // repeats remain for the current item
    } stat_t;

endpackage

/* hdl/rbr_stream_if.sv */
// Valid/ready stream interfaces for input pixels and output results.
// Depends on rbr_pkg.
interface rbr_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [rbr_pkg::CHAN_W-1:0] in_red;
    logic [rbr_pkg::CHAN_W-1:0] in_green;
    logic [rbr_pkg::CHAN_W-1:0] in_blue;

    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

interface rbr_res_if;
    logic                          valid;
    logic                          ready;
    logic [rbr_pkg::CHAN_W-1:0]    out_red;
    logic [rbr_pkg::CHAN_W-1:0]    out_green;
    logic [rbr_pkg::CHAN_W-1:0]    out_blue;
    logic [rbr_pkg::COL_OUT_W-1:0] column;
    logic                          last;

    modport source (output valid, out_red, out_green, out_blue, column, last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, column, last, output ready);
endinterface

/* hdl/rational_box_resampler_rgb_top.sv */
// Top level of the rational box resampler: APB register file plus the
// controller and datapath. Depends on rbr_pkg, rbr_stream_if, rbr_ctrl, rbr_datapath.
//
//   port            dir   protocol     transfer
//   pixel_stream    in    valid/ready  opcode + one RGB pixel
//   result_stream   out   valid/ready  averaged RGB pixel, column, last
//   psel..pready    in    APB          register write/read, pready tied high
//
// An add item walks px repeats, px = clamped up_factor; for each of the K kept output
// pixels it forms, the bit-serial divider (one quotient bit per cycle) runs over SW
// bits, SW = sum width (12 at default sizes). A clear item is handled in the idle state.
// Reset (rst_n low, asynchronous) zeroes sums, counters, column and output valid.
// A result waiting in the output register holds the sequencer, and with it the
// input, only once the next result is ready to load; otherwise input items are
// still taken while it waits.
module rational_box_resampler_rgb_top
#(
    parameter int MAX_WIDTH  = rbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbr_pkg::DEF_MAX_FACTOR
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rbr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rbr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    rbr_pix_if.sink                        pixel_stream,
    rbr_res_if.source                      result_stream
);

    logic [rbr_pkg::CFG_FACTOR_W-1:0] up_factor_reg;
    logic [rbr_pkg::CFG_FACTOR_W-1:0] down_factor_reg;
    logic [rbr_pkg::CFG_WIDTH_W-1:0]  line_width_reg;
    rbr_pkg::reg_idx_t                reg_idx;
    logic                             cfg_wr;
    rbr_pkg::cfg_t                    cfg;
    rbr_pkg::cmd_t                    cmd;
    rbr_pkg::stat_t                   st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= rbr_pkg::UP_FACTOR_RST;
            down_factor_reg <= rbr_pkg::DOWN_FACTOR_RST;
            line_width_reg  <= rbr_pkg::LINE_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rbr_pkg::REG_UP_FACTOR:
                begin
                    up_factor_reg <= pwdata[rbr_pkg::CFG_FACTOR_W-1:0];
                end
                rbr_pkg::REG_DOWN_FACTOR:
                begin
                    down_factor_reg <= pwdata[rbr_pkg::CFG_FACTOR_W-1:0];
                end
                rbr_pkg::REG_LINE_WIDTH:
                begin
                    line_width_reg <= pwdata[rbr_pkg::CFG_WIDTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            rbr_pkg::REG_UP_FACTOR:   prdata = rbr_pkg::APB_DATA_W'(up_factor_reg);
            rbr_pkg::REG_DOWN_FACTOR: prdata = rbr_pkg::APB_DATA_W'(down_factor_reg);
            rbr_pkg::REG_LINE_WIDTH:  prdata = rbr_pkg::APB_DATA_W'(line_width_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.up_factor   = up_factor_reg;
    assign cfg.down_factor = down_factor_reg;
    assign cfg.line_width  = line_width_reg;

    // Sequencer
    rbr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_stream.valid),
        .in_opcode (pixel_stream.opcode),
        .in_ready  (pixel_stream.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Sums, divider and output register
    rbr_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .in_red    (pixel_stream.in_red),
        .in_green  (pixel_stream.in_green),
        .in_blue   (pixel_stream.in_blue),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .out_red   (result_stream.out_red),
        .out_green (result_stream.out_green),
        .out_blue  (result_stream.out_blue),
        .column    (result_stream.column),
        .last      (result_stream.last)
    );

endmodule

/* hdl/rbr_ctrl.sv */
// Sequencer for the resampler: walks the repeats of one pixel, runs the
// divider for each kept output pixel and hands results to the output register.
// Depends on rbr_pkg.
module rbr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_opcode,
    output logic           in_ready,
    input  rbr_pkg::stat_t st,
    output rbr_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == rbr_pkg::OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (st.emit && st.keep)
                begin
                    state_next = S_DIV;
                end
                else if (!st.step_more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_run = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = st.item_more ? S_STEP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/rbr_datapath.sv */
// Datapath of the resampler: channel sums, repeat/sample counters, column,
// a bit-serial divider per channel and the output register.
// Depends on rbr_pkg.
module rbr_datapath
#(
    parameter int MAX_WIDTH  = rbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbr_pkg::DEF_MAX_FACTOR
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbr_pkg::cfg_t                 cfg,
    input  rbr_pkg::cmd_t                 cmd,
    output rbr_pkg::stat_t                st,
    input  logic [rbr_pkg::CHAN_W-1:0]    in_red,
    input  logic [rbr_pkg::CHAN_W-1:0]    in_green,
    input  logic [rbr_pkg::CHAN_W-1:0]    in_blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rbr_pkg::CHAN_W-1:0]    out_red,
    output logic [rbr_pkg::CHAN_W-1:0]    out_green,
    output logic [rbr_pkg::CHAN_W-1:0]    out_blue,
    output logic [rbr_pkg::COL_OUT_W-1:0] column,
    output logic                          last
);

    localparam int CHAN_MAX = (1 << rbr_pkg::CHAN_W) - 1;
    localparam int FW   = $clog2(MAX_FACTOR + 1);          // factor 1..MAX_FACTOR
    localparam int CNW  = $clog2(MAX_FACTOR);              // stored count, remainder
    localparam int SW   = $clog2(MAX_FACTOR * CHAN_MAX + 1);
    localparam int COLW = $clog2(MAX_WIDTH + 1);
    localparam int DCW  = $clog2(SW);
    localparam int CLW  = (FW > rbr_pkg::CFG_FACTOR_W) ? FW : rbr_pkg::CFG_FACTOR_W;
    localparam int WLW  = (COLW > rbr_pkg::CFG_WIDTH_W) ? COLW : rbr_pkg::CFG_WIDTH_W;

    // One restoring-division step: shift in the next dividend bit
    function automatic logic [CNW+SW-1:0] div_step(
        input logic [CNW-1:0] rem,
        input logic [SW-1:0]  dq,
        input logic [FW-1:0]  d
    );
        logic [CNW:0] trial;
        logic [CNW:0] diff;
        trial = {rem, dq[SW-1]};
        diff  = trial - (CNW+1)'(d);
        if (trial >= (CNW+1)'(d))
        begin
            return {diff[CNW-1:0], dq[SW-2:0], 1'b1};
        end
        return {trial[CNW-1:0], dq[SW-2:0], 1'b0};
    endfunction

    // Clamped configuration
    logic [CLW-1:0]  up_ext, down_ext, px_wide, qx_wide;
    logic [WLW-1:0]  lw_ext, kw_wide;
    logic [FW-1:0]   px, qx;
    logic [COLW-1:0] kw;

    // State
    logic [rbr_pkg::CHAN_W-1:0] pix_red_reg, pix_green_reg, pix_blue_reg;
    logic [FW-1:0]   step_left_reg;
    logic [SW-1:0]   sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [CNW-1:0]  count_reg;
    logic [COLW-1:0] col_reg;
    logic [CNW-1:0]  rem_red_reg, rem_green_reg, rem_blue_reg;
    logic [SW-1:0]   dq_red_reg, dq_green_reg, dq_blue_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic [COLW-1:0] col_pend_reg;
    logic            last_pend_reg;
    logic            out_valid_reg;
    logic [rbr_pkg::CHAN_W-1:0]    out_red_reg, out_green_reg, out_blue_reg;
    logic [rbr_pkg::COL_OUT_W-1:0] column_reg;
    logic                          last_reg;

    // Step arithmetic
    logic [SW-1:0]   sum_red_add, sum_green_add, sum_blue_add;
    logic [FW-1:0]   cnt_inc;
    logic [FW-1:0]   steps_after;
    logic [COLW:0]   col_inc;
    logic            next_keep;
    logic            last_now;
    logic            load_div;

    // Factor and width clamping
    always_comb
    begin
        up_ext   = CLW'(cfg.up_factor);
        down_ext = CLW'(cfg.down_factor);
        lw_ext   = WLW'(cfg.line_width);
        if (up_ext == '0)
        begin
            px_wide = CLW'(1);
        end
        else if (up_ext > CLW'(MAX_FACTOR))
        begin
            px_wide = CLW'(MAX_FACTOR);
        end
        else
        begin
            px_wide = up_ext;
        end
        if (down_ext == '0)
        begin
            qx_wide = CLW'(1);
        end
        else if (down_ext > CLW'(MAX_FACTOR))
        begin
            qx_wide = CLW'(MAX_FACTOR);
        end
        else
        begin
            qx_wide = down_ext;
        end
        kw_wide = (lw_ext > WLW'(MAX_WIDTH)) ? WLW'(MAX_WIDTH) : lw_ext;
    end

    assign px = FW'(px_wide);
    assign qx = FW'(qx_wide);
    assign kw = COLW'(kw_wide);

    // Accumulate and look ahead for the last result of this item
    assign sum_red_add   = sum_red_reg + SW'(pix_red_reg);
    assign sum_green_add = sum_green_reg + SW'(pix_green_reg);
    assign sum_blue_add  = sum_blue_reg + SW'(pix_blue_reg);
    assign cnt_inc       = FW'(count_reg) + FW'(1);
    assign steps_after   = step_left_reg - FW'(1);
    assign col_inc       = {1'b0, col_reg} + (COLW+1)'(1);
    assign next_keep     = col_inc < {1'b0, kw};
    assign last_now      = !((steps_after >= qx) && next_keep);

    assign st.emit      = cnt_inc >= qx;
    assign st.keep      = col_reg < kw;
    assign st.step_more = steps_after != '0;
    assign st.div_done  = div_cnt_reg == '0;
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.item_more = step_left_reg != '0;

    assign load_div = cmd.step && st.emit && st.keep;

    // Control state: counters, sums, column, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_left_reg <= '0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            count_reg     <= '0;
            col_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                sum_red_reg   <= '0;
                sum_green_reg <= '0;
                sum_blue_reg  <= '0;
                count_reg     <= '0;
                col_reg       <= '0;
            end
            if (cmd.start)
            begin
                step_left_reg <= px;
            end
            if (cmd.step)
            begin
                step_left_reg <= steps_after;
                if (st.emit)
                begin
                    sum_red_reg   <= '0;
                    sum_green_reg <= '0;
                    sum_blue_reg  <= '0;
                    count_reg     <= '0;
                    if (st.keep)
                    begin
                        col_reg <= COLW'(col_inc);
                    end
                end
                else
                begin
                    sum_red_reg   <= sum_red_add;
                    sum_green_reg <= sum_green_add;
                    sum_blue_reg  <= sum_blue_add;
                    count_reg     <= CNW'(cnt_inc);
                end
            end
            // Divider iteration count
            if (load_div)
            begin
                div_cnt_reg <= DCW'(SW - 1);
            end
            else if (cmd.div_run && !st.div_done)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            // Output register occupancy
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: pixel latch, divider, pending tag, output register
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pix_red_reg   <= in_red;
            pix_green_reg <= in_green;
            pix_blue_reg  <= in_blue;
        end
        if (load_div)
        begin
            dq_red_reg    <= sum_red_add;
            dq_green_reg  <= sum_green_add;
            dq_blue_reg   <= sum_blue_add;
            rem_red_reg   <= '0;
            rem_green_reg <= '0;
            rem_blue_reg  <= '0;
            col_pend_reg  <= col_reg;
            last_pend_reg <= last_now;
        end
        else if (cmd.div_run)
        begin
            {rem_red_reg, dq_red_reg}     <= div_step(rem_red_reg, dq_red_reg, qx);
            {rem_green_reg, dq_green_reg} <= div_step(rem_green_reg, dq_green_reg, qx);
            {rem_blue_reg, dq_blue_reg}   <= div_step(rem_blue_reg, dq_blue_reg, qx);
        end
        if (cmd.out_load)
        begin
            out_red_reg   <= dq_red_reg[rbr_pkg::CHAN_W-1:0];
            out_green_reg <= dq_green_reg[rbr_pkg::CHAN_W-1:0];
            out_blue_reg  <= dq_blue_reg[rbr_pkg::CHAN_W-1:0];
            column_reg    <= rbr_pkg::COL_OUT_W'(col_pend_reg);
            last_reg      <= last_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign column    = column_reg;
    assign last      = last_reg;

    // Checks
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) < MAX_FACTOR)
        else $error("sample count out of range");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        load_div |=> (div_cnt_reg == DCW'(SW - 1)))
        else $error("divider not loaded with full iteration count");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (sum_red_reg == '0 && count_reg == '0 && col_reg == '0))
        else $error("clear left line state behind");

endmodule

/* tb/rbr_resample_checker.sv */
// Scoreboard for the rational box resampler: tracks register writes, predicts
// the averaged pixels of each input transfer and compares them with the results.
// Depends on rbr_pkg and the stream interfaces in rbr_stream_if.
module rbr_resample_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rbr_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [rbr_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    rbr_pix_if                             pix,
    rbr_res_if                             res,
    output int                             fail_count,
    output int                             expected_left
);

    typedef struct packed {
        logic [rbr_pkg::CHAN_W-1:0]    red;
        logic [rbr_pkg::CHAN_W-1:0]    green;
        logic [rbr_pkg::CHAN_W-1:0]    blue;
        logic [rbr_pkg::COL_OUT_W-1:0] column;
        logic                          last;
    } out_pixel_t;

    // Pixels predicted but not yet seen on the result stream
    out_pixel_t expected_pixels[$];
    out_pixel_t seen_pixel;
    out_pixel_t want_pixel;

    // Shadow registers and line state
    logic [rbr_pkg::CFG_FACTOR_W-1:0] up_reg;
    logic [rbr_pkg::CFG_FACTOR_W-1:0] down_reg;
    logic [rbr_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [rbr_pkg::APB_DATA_W-1:0]   read_value;
    int unsigned                      acc_red;
    int unsigned                      acc_green;
    int unsigned                      acc_blue;
    int unsigned                      samples;
    int unsigned                      next_column;

    // Out-of-range factors: 0 acts as 1, above the maximum acts as the maximum
    function automatic int unsigned factor_used(
        input logic [rbr_pkg::CFG_FACTOR_W-1:0] v
    );
        if (v == '0)
            return 32'd1;
        if (32'(v) > 32'(rbr_pkg::DEF_MAX_FACTOR))
            return 32'(rbr_pkg::DEF_MAX_FACTOR);
        return 32'(v);
    endfunction

    function automatic void clear_line();
        acc_red     = 0;
        acc_green   = 0;
        acc_blue    = 0;
        samples     = 0;
        next_column = 0;
    endfunction

    // Feed one pixel up_factor times and queue every kept output pixel
    function automatic void resample_pixel(input logic [rbr_pkg::CHAN_W-1:0] r,
                                           input logic [rbr_pkg::CHAN_W-1:0] g,
                                           input logic [rbr_pkg::CHAN_W-1:0] b);
        int unsigned px;
        int unsigned qx;
        int unsigned kept;
        int          queued_before;
        out_pixel_t  p;
        px            = factor_used(up_reg);
        qx            = factor_used(down_reg);
        kept          = (32'(width_reg) > 32'(rbr_pkg::DEF_MAX_WIDTH)) ?
                        32'(rbr_pkg::DEF_MAX_WIDTH) : 32'(width_reg);
        queued_before = expected_pixels.size();
        for (int unsigned i = 0; i < px; i++)
        begin
            acc_red   += 32'(r);
            acc_green += 32'(g);
            acc_blue  += 32'(b);
            samples++;
            // a lowered down factor fires as soon as the count reaches it
            if (samples >= qx)
            begin
                if (next_column < kept)
                begin
                    p.red    = rbr_pkg::CHAN_W'(acc_red / qx);
                    p.green  = rbr_pkg::CHAN_W'(acc_green / qx);
                    p.blue   = rbr_pkg::CHAN_W'(acc_blue / qx);
                    p.column = rbr_pkg::COL_OUT_W'(next_column);
                    p.last   = 1'b0;
                    expected_pixels.push_back(p);
                    next_column++;
                end
                // sums are consumed even when the pixel falls past the line
                acc_red   = 0;
                acc_green = 0;
                acc_blue  = 0;
                samples   = 0;
            end
        end
        if (expected_pixels.size() > queued_before)
            expected_pixels[expected_pixels.size()-1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg        = rbr_pkg::UP_FACTOR_RST;
            down_reg      = rbr_pkg::DOWN_FACTOR_RST;
            width_reg     = rbr_pkg::LINE_WIDTH_RST;
            clear_line();
            expected_pixels.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            // register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (rbr_pkg::reg_idx_t'(paddr[3:2]))
                        rbr_pkg::REG_UP_FACTOR:
                            up_reg = pwdata[rbr_pkg::CFG_FACTOR_W-1:0];
                        rbr_pkg::REG_DOWN_FACTOR:
                            down_reg = pwdata[rbr_pkg::CFG_FACTOR_W-1:0];
                        rbr_pkg::REG_LINE_WIDTH:
                            width_reg = pwdata[rbr_pkg::CFG_WIDTH_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (rbr_pkg::reg_idx_t'(paddr[3:2]))
                        rbr_pkg::REG_UP_FACTOR:
                            read_value = rbr_pkg::APB_DATA_W'(up_reg);
                        rbr_pkg::REG_DOWN_FACTOR:
                            read_value = rbr_pkg::APB_DATA_W'(down_reg);
                        rbr_pkg::REG_LINE_WIDTH:
                            read_value = rbr_pkg::APB_DATA_W'(width_reg);
                        default:
                            read_value = prdata;
                    endcase
                    if (prdata !== read_value)
                    begin
                        fail_count++;
                        $display("%0t: register %0d read: expected 0x%0h, got 0x%0h",
                                 $time, paddr[3:2], read_value, prdata);
                    end
                end
            end

            // input transfer
            if (pix.valid && pix.ready)
            begin
                if (pix.opcode == rbr_pkg::OP_CLEAR)
                    clear_line();
                else
                    resample_pixel(pix.in_red, pix.in_green, pix.in_blue);
            end

            // result transfer
            if (res.valid && res.ready)
            begin
                seen_pixel = '{res.out_red, res.out_green, res.out_blue, res.column,
                               res.last};
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pixel: expected none, got %s",
                             $time, $sformatf("r=%0d g=%0d b=%0d col=%0d last=%0b",
                             seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                             seen_pixel.column, seen_pixel.last));
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (seen_pixel !== want_pixel)
                    begin
                        fail_count++;
                        $display("%0t: pixel mismatch: expected %s, got %s",
                                 $time,
                                 $sformatf("r=%0d g=%0d b=%0d col=%0d last=%0b",
                                           want_pixel.red, want_pixel.green,
                                           want_pixel.blue, want_pixel.column,
                                           want_pixel.last),
                                 $sformatf("r=%0d g=%0d b=%0d col=%0d last=%0b",
                                           seen_pixel.red, seen_pixel.green,
                                           seen_pixel.blue, seen_pixel.column,
                                           seen_pixel.last));
                    end
                end
            end
            expected_left = expected_pixels.size();
        end
    end

endmodule

/* tb/tb_rational_box_resampler_rgb_top.sv */
// Testbench top for the rational box resampler: clock, reset, register setup,
// pixel stimulus and result back-pressure; the verdict comes from the checker.
// Depends on rbr_pkg, rbr_stream_if, rbr_resample_checker and the block itself.
module tb_rational_box_resampler_rgb_top;

    localparam rbr_pkg::reg_idx_t REG_SPARE   = 2'd3;
    localparam int                FACTOR_MASK = (1 << rbr_pkg::CFG_FACTOR_W) - 1;
    localparam int                WIDTH_MASK  = (1 << rbr_pkg::CFG_WIDTH_W) - 1;
    // time for the longest add item: sixteen repeats and sixteen kept pixels through the divider
    localparam int                ITEM_CYCLES = 250;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rbr_pkg::APB_ADDR_W-1:0] paddr;
    logic [rbr_pkg::APB_DATA_W-1:0] pwdata;
    logic [rbr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    int                             fail_count;
    int                             expected_left;
    bit                             calm;
    bit                             hold_req;
    bit                             hold_done;

    rbr_pix_if pixel_stream ();
    rbr_res_if result_stream ();

    rational_box_resampler_rgb_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_stream  (pixel_stream),
        .result_stream (result_stream)
    );

    rbr_resample_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pix           (pixel_stream),
        .res           (result_stream),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        result_stream.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_stream.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                result_stream.ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    // one APB access: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input rbr_pkg::reg_idx_t idx,
                            input logic [rbr_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a field with occasional junk above it, then read it back
    task automatic write_field(input rbr_pkg::reg_idx_t idx, input int mask,
                               input int value);
        logic [rbr_pkg::APB_DATA_W-1:0] junk;
        junk = ($urandom_range(3) == 0) ? ($urandom() & ~mask) : '0;
        apb_xfer(1'b1, idx, junk | (value & mask));
        apb_xfer(1'b0, idx, '0);
    endtask

    task automatic write_config(input int up, input int down, input int width);
        write_field(rbr_pkg::REG_UP_FACTOR, FACTOR_MASK, up);
        write_field(rbr_pkg::REG_DOWN_FACTOR, FACTOR_MASK, down);
        write_field(rbr_pkg::REG_LINE_WIDTH, WIDTH_MASK, width);
    endtask

    // offer one input transfer, with an occasional gap before it
    task automatic push_pixel(input logic op, input int r, input int g, input int b);
        if (!calm && $urandom_range(99) < 9)
        begin
            pixel_stream.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pixel_stream.valid    <= 1'b1;
        pixel_stream.opcode   <= op;
        pixel_stream.in_red   <= rbr_pkg::CHAN_W'(r);
        pixel_stream.in_green <= rbr_pkg::CHAN_W'(g);
        pixel_stream.in_blue  <= rbr_pkg::CHAN_W'(b);
        do @(posedge clk); while (!pixel_stream.ready);
    endtask

    // stop offering and wait until every predicted pixel has come out
    task automatic wait_drained();
        pixel_stream.valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
    endtask

    // drained, plus time for an item that forms no kept pixel
    task automatic settle();
        wait_drained();
        repeat (ITEM_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_channel();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int pick_factor();
        case ($urandom_range(19))
            0, 1:       return 0;
            2, 3:       return $urandom_range(17, 31);
            4, 5, 6:    return $urandom_range(9, 16);
            default:    return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(9))
            0:          return 0;
            1:          return $urandom_range(4097, 8191);
            2, 3:       return $urandom_range(1, 12);
            default:    return $urandom_range(64, 4096);
        endcase
    endfunction

    // a scan line: usually a clear, then pixels with a little clear noise
    task automatic random_line(input int n_items);
        logic op;
        if ($urandom_range(3) != 0)
            push_pixel(rbr_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
        for (int k = 0; k < n_items; k++)
        begin
            op = ($urandom_range(99) < 6) ? rbr_pkg::OP_CLEAR : rbr_pkg::OP_ADD;
            push_pixel(op, pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        pixel_stream.valid    <= 1'b0;
        pixel_stream.opcode   <= rbr_pkg::OP_ADD;
        pixel_stream.in_red   <= '0;
        pixel_stream.in_green <= '0;
        pixel_stream.in_blue  <= '0;
        calm                  = 1'b0;
        hold_req              = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: one output pixel per input
        push_pixel(rbr_pkg::OP_ADD, 0, 0, 0);
        push_pixel(rbr_pkg::OP_ADD, 255, 255, 255);
        push_pixel(rbr_pkg::OP_ADD, 8'hAA, 8'h55, 8'h0F);
        settle();

        // largest up factor: sixteen pixels from one input, then a clear
        write_config(16, 1, 4096);
        push_pixel(rbr_pkg::OP_ADD, 255, 0, 128);
        push_pixel(rbr_pkg::OP_CLEAR, 255, 255, 255);
        settle();

        // largest down factor with full sums
        write_config(16, 16, 4096);
        push_pixel(rbr_pkg::OP_ADD, 255, 1, 254);
        settle();
        write_config(5, 16, 4096);
        push_pixel(rbr_pkg::OP_ADD, 200, 100, 50);
        push_pixel(rbr_pkg::OP_ADD, 7, 255, 0);
        push_pixel(rbr_pkg::OP_ADD, 255, 255, 255);
        push_pixel(rbr_pkg::OP_ADD, 1, 2, 3);
        settle();

        // zero and oversized factors, oversized width; partial sums kept
        write_config(0, 31, 8191);
        push_pixel(rbr_pkg::OP_CLEAR, 0, 0, 0);
        push_pixel(rbr_pkg::OP_ADD, 255, 255, 255);
        push_pixel(rbr_pkg::OP_ADD, 128, 64, 32);
        settle();
        // down factor lowered mid line: fires at once on the next sample
        write_config(2, 0, 8191);
        push_pixel(rbr_pkg::OP_ADD, 250, 3, 77);
        settle();

        // width of zero keeps nothing; small widths drop the tail
        write_config(2, 1, 0);
        push_pixel(rbr_pkg::OP_CLEAR, 9, 9, 9);
        push_pixel(rbr_pkg::OP_ADD, 10, 20, 30);
        settle();
        write_config(4, 1, 1);
        push_pixel(rbr_pkg::OP_CLEAR, 0, 0, 0);
        push_pixel(rbr_pkg::OP_ADD, 40, 50, 60);
        push_pixel(rbr_pkg::OP_ADD, 70, 80, 90);
        settle();
        write_config(3, 2, 3);
        apb_xfer(1'b1, REG_SPARE, $urandom());
        push_pixel(rbr_pkg::OP_CLEAR, 0, 0, 0);
        push_pixel(rbr_pkg::OP_ADD, 11, 22, 33);
        push_pixel(rbr_pkg::OP_ADD, 255, 128, 0);
        settle();

        // random phases: calm stretch, long result hold-off, sender pause
        for (int phase = 0; phase < 6; phase++)
        begin
            // the hold-off phase needs a steady flow of kept pixels
            if (phase == 3)
                write_config(8, 3, 4096);
            else
                write_config(pick_factor(), pick_factor(), pick_width());
            calm = (phase == 2);
            if (phase == 3)
                hold_req = 1'b1;
            random_line(12);
            if (phase == 4)
                wait_drained();
            random_line(12);
            settle();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rbr_pkg.sv
hdl/rbr_stream_if.sv
hdl/rbr_ctrl.sv
hdl/rbr_datapath.sv
hdl/rational_box_resampler_rgb_top.sv
tb/rbr_resample_checker.sv
tb/tb_rational_box_resampler_rgb_top.sv
